>>> design/hgdp_pkg.sv
package hgdp_pkg;

  localparam int unsigned USAGE_DEPTH_DEF    = 16;
  localparam int unsigned MAX_BUTTON_RUN_DEF = 32;

  localparam logic [19:0] POS_MAX = 20'hFFFFF;
  localparam logic [7:0]  LONG_PREFIX = 8'hFE;

  // item types
  localparam logic [1:0] TYPE_MAIN   = 2'd0;
  localparam logic [1:0] TYPE_GLOBAL = 2'd1;
  localparam logic [1:0] TYPE_LOCAL  = 2'd2;

  // main tags
  localparam logic [3:0] TAG_INPUT    = 4'h8;
  localparam logic [3:0] TAG_COLL     = 4'hA;
  localparam logic [3:0] TAG_END_COLL = 4'hC;

  // global tags
  localparam logic [3:0] TAG_USAGE_PAGE = 4'h0;
  localparam logic [3:0] TAG_LOG_MIN    = 4'h1;
  localparam logic [3:0] TAG_LOG_MAX    = 4'h2;
  localparam logic [3:0] TAG_REP_SIZE   = 4'h7;
  localparam logic [3:0] TAG_REP_ID     = 4'h8;
  localparam logic [3:0] TAG_REP_COUNT  = 4'h9;

  // local tags
  localparam logic [3:0] TAG_USAGE     = 4'h0;
  localparam logic [3:0] TAG_USAGE_MIN = 4'h1;
  localparam logic [3:0] TAG_USAGE_MAX = 4'h2;

  localparam logic [15:0] PAGE_DESKTOP = 16'h0001;
  localparam logic [15:0] PAGE_BUTTON  = 16'h0009;
  localparam logic [15:0] USAGE_X      = 16'h0030;
  localparam logic [15:0] USAGE_RZ     = 16'h0035;
  localparam logic [15:0] USAGE_HAT    = 16'h0039;

  localparam logic [1:0] CAP_AXIS    = 2'd0;
  localparam logic [1:0] CAP_HAT     = 2'd1;
  localparam logic [1:0] CAP_BUTTON  = 2'd2;
  localparam logic [1:0] CAP_SUMMARY = 2'd3;

  typedef enum logic [1:0] {
    PH_PREFIX,
    PH_DATA,
    PH_SKIP
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EMIT,
    ST_FINISH,
    ST_SUMMARY
  } state_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic emit;
    logic finish;
    logic summary;
  } cmd_t;

  typedef struct packed {
    logic item_done;
    logic is_input;
    logic more;
    logic out_free;
    logic final_seen;
  } status_t;

  typedef struct packed {
    logic [1:0]  cap_kind;
    logic [15:0] bit_offset;
    logic [7:0]  bit_size;
    logic [31:0] logical_min;
    logic [31:0] logical_max;
    logic [15:0] usage_code;
    logic [12:0] report_length;
    logic [7:0]  report_tag;
    logic        device_found;
    logic        parse_error;
    logic        overflow_flag;
    logic        run_last;
  } res_t;

  function automatic logic [2:0] item_len(input logic [7:0] prefix);
    item_len = (prefix[1:0] == 2'd3) ? 3'd4 : {1'b0, prefix[1:0]};
  endfunction

endpackage

>>> design/hgdp_in_if.sv
interface hgdp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] descriptor_byte;
  logic       final_byte;

  modport source (output valid, output descriptor_byte, output final_byte, input ready);
  modport sink (input valid, input descriptor_byte, input final_byte, output ready);
endinterface

>>> design/hgdp_out_if.sv
interface hgdp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cap_kind;
  logic [15:0] bit_offset;
  logic [7:0]  bit_size;
  logic [31:0] logical_min;
  logic [31:0] logical_max;
  logic [15:0] usage_code;
  logic [12:0] report_length;
  logic [7:0]  report_tag;
  logic        device_found;
  logic        parse_error;
  logic        overflow_flag;
  logic        run_last;

  modport source (
    output valid, output cap_kind, output bit_offset, output bit_size,
    output logical_min, output logical_max, output usage_code,
    output report_length, output report_tag, output device_found,
    output parse_error, output overflow_flag, output run_last, input ready
  );
  modport sink (
    input valid, input cap_kind, input bit_offset, input bit_size,
    input logical_min, input logical_max, input usage_code,
    input report_length, input report_tag, input device_found,
    input parse_error, input overflow_flag, input run_last, output ready
  );
endinterface

>>> design/hgdp_ctrl.sv
module hgdp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_final_i,
  output logic              in_ready_o,
  input  hgdp_pkg::status_t status_i,
  output hgdp_pkg::cmd_t    cmd_o
);
  import hgdp_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (status_i.item_done) state_d = ST_EXEC;
          else if (in_final_i) state_d = ST_SUMMARY;
        end
      end
      ST_EXEC: begin
        if (status_i.is_input) state_d = ST_EMIT;
        else if (status_i.final_seen) state_d = ST_SUMMARY;
        else state_d = ST_IDLE;
      end
      ST_EMIT: begin
        if (!status_i.more) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        state_d = status_i.final_seen ? ST_SUMMARY : ST_IDLE;
      end
      ST_SUMMARY: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_EXEC:    cmd_o.exec = 1'b1;
      ST_EMIT:    cmd_o.emit = status_i.more;
      ST_FINISH:  cmd_o.finish = 1'b1;
      ST_SUMMARY: cmd_o.summary = status_i.out_free;
      default: ;
    endcase
  end

endmodule

>>> design/hgdp_dp.sv
module hgdp_dp #(
  parameter int unsigned USAGE_DEPTH    = hgdp_pkg::USAGE_DEPTH_DEF,
  parameter int unsigned MAX_BUTTON_RUN = hgdp_pkg::MAX_BUTTON_RUN_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hgdp_pkg::cmd_t    cmd_i,
  output hgdp_pkg::status_t status_o,
  input  logic [7:0]        byte_i,
  input  logic              final_i,
  input  logic [7:0]        target_i,
  output hgdp_pkg::res_t    res_o,
  output logic              res_valid_o,
  input  logic              res_ready_i
);
  import hgdp_pkg::*;

  localparam int unsigned MASK_W = (USAGE_DEPTH > MAX_BUTTON_RUN) ? USAGE_DEPTH : MAX_BUTTON_RUN;
  localparam int unsigned IDX_W  = (MASK_W > 1) ? $clog2(MASK_W) : 1;
  localparam int unsigned UIDX_W = (USAGE_DEPTH > 1) ? $clog2(USAGE_DEPTH) : 1;
  localparam int unsigned UCNT_W = $clog2(USAGE_DEPTH + 1);
  localparam logic [UCNT_W-1:0] UCNT_MAX = UCNT_W'(USAGE_DEPTH);
  localparam logic [16:0] BRUN_MAX = 17'(MAX_BUTTON_RUN);

  // parser and item state
  phase_e        phase_q, phase_d;
  logic [7:0]    prefix_q, prefix_d;
  logic [2:0]    left_q, left_d;
  logic [31:0]   acc_q, acc_d;
  logic [15:0]   upage_q, upage_d;
  logic [31:0]   lmin_q, lmin_d;
  logic [31:0]   lmax_q, lmax_d;
  logic [7:0]    rsize_q, rsize_d;
  logic [31:0]   rcount_q, rcount_d;
  logic [7:0]    rid_q, rid_d;
  logic [7:0]    chosen_q, chosen_d;
  logic [15:0]   umin_q, umin_d;
  logic [15:0]   umax_q, umax_d;
  logic [UCNT_W-1:0] ucount_q, ucount_d;
  logic [7:0]    depth_q, depth_d;
  logic [8:0]    devcnt_q, devcnt_d;
  logic [19:0]   pos_q, pos_d;
  logic          err_q, err_d;
  logic          ovf_q, ovf_d;
  logic          final_q, final_d;

  // emission run
  logic [MASK_W-1:0] mask_q, mask_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              btn_q, btn_d;
  logic [20:0]       off_q, off_d;
  logic [39:0]       prod_q, prod_d;

  logic  valid_q, valid_d;
  res_t  res_q, res_d;

  logic [15:0] ustore_q [USAGE_DEPTH];
  logic        us_we;

  logic [1:0]  itype;
  logic [3:0]  itag;
  logic [31:0] data;
  logic        out_free;
  logic        cur;
  logic [MASK_W-1:0] mask_clr;
  logic [MASK_W-1:0] amask;
  logic [MASK_W-1:0] bmask;
  logic [16:0] brun;
  logic [20:0] pos_plus;
  logic [19:0] pos_id;
  logic [40:0] pos_sum;
  logic [20:0] len_bits;
  logic [15:0] ucur;
  logic [1:0]  b_idx;
  logic [31:0] acc_new;

  assign itype    = prefix_q[3:2];
  assign itag     = prefix_q[7:4];
  assign data     = acc_q;
  assign out_free = !valid_q || res_ready_i;
  assign cur      = mask_q[idx_q];
  assign mask_clr = mask_q & ~(MASK_W'(1) << idx_q);
  assign ucur     = ustore_q[idx_q[UIDX_W-1:0]];
  assign b_idx    = 2'(item_len(prefix_q) - left_q);
  assign acc_new  = acc_q | (32'(byte_i) << {b_idx, 3'b000});

  assign status_o.item_done  = ((phase_q == PH_PREFIX) && (byte_i != LONG_PREFIX) &&
                                (item_len(byte_i) == 3'd0)) ||
                               ((phase_q == PH_DATA) && (left_q == 3'd1));
  assign status_o.is_input   = (itype == TYPE_MAIN) && (itag == TAG_INPUT);
  assign status_o.more       = |mask_q;
  assign status_o.out_free   = out_free;
  assign status_o.final_seen = final_q;

  // candidate masks for the input item
  always_comb begin
    amask = '0;
    for (int j = 0; j < USAGE_DEPTH; j++) begin
      amask[j] = (UCNT_W'(j) < ucount_q) &&
                 (((ustore_q[j] >= USAGE_X) && (ustore_q[j] <= USAGE_RZ)) ||
                  (ustore_q[j] == USAGE_HAT));
    end
  end

  assign brun = (17'(umax_q) - 17'(umin_q) + 17'd1 > BRUN_MAX) ? BRUN_MAX
              : (17'(umax_q) - 17'(umin_q) + 17'd1);

  always_comb begin
    for (int j = 0; j < MASK_W; j++) begin
      bmask[j] = (17'(j) < brun);
    end
  end

  assign pos_plus = {1'b0, pos_q} + 21'd8;
  assign pos_id   = (chosen_q != rid_q) ? ((pos_plus > {1'b0, POS_MAX}) ? POS_MAX : pos_plus[19:0])
                                        : pos_q;
  assign pos_sum  = {21'b0, pos_q} + {1'b0, prod_q};
  assign len_bits = ({1'b0, pos_q} + 21'd7) >> 3;

  always_comb begin
    phase_d  = phase_q;  prefix_d = prefix_q; left_d   = left_q;   acc_d    = acc_q;
    upage_d  = upage_q;  lmin_d   = lmin_q;   lmax_d   = lmax_q;   rsize_d  = rsize_q;
    rcount_d = rcount_q; rid_d    = rid_q;    chosen_d = chosen_q; umin_d   = umin_q;
    umax_d   = umax_q;   ucount_d = ucount_q; depth_d  = depth_q;  devcnt_d = devcnt_q;
    pos_d    = pos_q;    err_d    = err_q;    ovf_d    = ovf_q;    final_d  = final_q;
    mask_d   = mask_q;   idx_d    = idx_q;    btn_d    = btn_q;    off_d    = off_q;
    prod_d   = prod_q;
    valid_d  = valid_q && !res_ready_i;
    res_d    = res_q;
    us_we    = 1'b0;

    if (cmd_i.load) begin
      final_d = final_i;
      unique case (phase_q)
        PH_PREFIX: begin
          prefix_d = byte_i;
          acc_d    = '0;
          if (byte_i == LONG_PREFIX) begin
            err_d   = 1'b1;
            phase_d = PH_SKIP;
          end else begin
            left_d = item_len(byte_i);
            if (item_len(byte_i) != 3'd0) phase_d = PH_DATA;
          end
        end
        PH_DATA: begin
          acc_d  = acc_new;
          left_d = left_q - 3'd1;
          if (left_q == 3'd1) phase_d = PH_PREFIX;
        end
        default: ;
      endcase
      // truncated item at the end of the descriptor
      if (final_i && (phase_d == PH_DATA)) err_d = 1'b1;
    end

    if (cmd_i.exec) begin
      unique case (itype)
        TYPE_MAIN: begin
          if (itag == TAG_INPUT) begin
            mask_d = '0;
            btn_d  = 1'b0;
            idx_d  = '0;
            off_d  = {1'b0, pos_q};
            prod_d = rcount_q * rsize_q;
            if ($signed(devcnt_q) == $signed({1'b0, target_i})) begin
              chosen_d = rid_q;
              pos_d    = pos_id;
              off_d    = {1'b0, pos_id};
              if (!data[0]) begin
                if (upage_q == PAGE_DESKTOP) begin
                  mask_d = amask;
                end else if ((upage_q == PAGE_BUTTON) && (umax_q >= umin_q)) begin
                  mask_d = bmask;
                  btn_d  = 1'b1;
                  if (17'(umax_q) - 17'(umin_q) + 17'd1 > BRUN_MAX) ovf_d = 1'b1;
                end
              end
            end
          end else begin
            if ((itag == TAG_COLL) && (depth_q != 8'hFF)) depth_d = depth_q + 8'd1;
            else if ((itag == TAG_END_COLL) && (depth_q != 8'h00)) depth_d = depth_q - 8'd1;
            ucount_d = '0;
            umin_d   = '0;
            umax_d   = '0;
          end
        end
        TYPE_GLOBAL: begin
          unique case (itag)
            TAG_USAGE_PAGE: upage_d  = data[15:0];
            TAG_LOG_MIN:    lmin_d   = data;
            TAG_LOG_MAX:    lmax_d   = data;
            TAG_REP_SIZE:   rsize_d  = (data > 32'd255) ? 8'hFF : data[7:0];
            TAG_REP_ID:     rid_d    = data[7:0];
            TAG_REP_COUNT:  rcount_d = data;
            default: ;
          endcase
        end
        TYPE_LOCAL: begin
          unique case (itag)
            TAG_USAGE: begin
              if (depth_q == 8'h00) begin
                // top-level usage counts a device
                if ($signed(devcnt_q) < $signed(9'd255)) devcnt_d = devcnt_q + 9'd1;
              end else if (ucount_q < UCNT_MAX) begin
                us_we    = 1'b1;
                ucount_d = ucount_q + UCNT_W'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            TAG_USAGE_MIN: umin_d = data[15:0];
            TAG_USAGE_MAX: umax_d = data[15:0];
            default: ;
          endcase
        end
        default: ;
      endcase
    end

    if (cmd_i.emit && (!cur || out_free)) begin
      mask_d = mask_clr;
      idx_d  = idx_q + IDX_W'(1);
      off_d  = off_q + {13'b0, rsize_q};
      if (cur) begin
        valid_d             = 1'b1;
        res_d               = '0;
        res_d.cap_kind      = btn_q ? CAP_BUTTON : ((ucur == USAGE_HAT) ? CAP_HAT : CAP_AXIS);
        res_d.bit_offset    = (off_q > 21'h00FFFF) ? 16'hFFFF : off_q[15:0];
        res_d.bit_size      = rsize_q;
        res_d.logical_min   = lmin_q;
        res_d.logical_max   = lmax_q;
        res_d.usage_code    = btn_q ? (umin_q + 16'(idx_q)) : ucur;
        res_d.device_found  = 1'b1;
        res_d.parse_error   = err_q;
        res_d.overflow_flag = ovf_q;
        res_d.run_last      = (mask_clr == '0) && !final_q;
      end
    end

    if (cmd_i.finish) begin
      pos_d    = (pos_sum > {21'b0, POS_MAX}) ? POS_MAX : pos_sum[19:0];
      ucount_d = '0;
      umin_d   = '0;
      umax_d   = '0;
    end

    if (cmd_i.summary) begin
      valid_d             = 1'b1;
      res_d               = '0;
      res_d.cap_kind      = CAP_SUMMARY;
      res_d.report_length = (len_bits > 21'd8191) ? 13'h1FFF : len_bits[12:0];
      res_d.report_tag    = chosen_q;
      res_d.device_found  = !devcnt_q[8] && ($signed(devcnt_q) >= $signed({1'b0, target_i}));
      res_d.parse_error   = err_q;
      res_d.overflow_flag = ovf_q;
      res_d.run_last      = 1'b1;
      // restart for the next descriptor
      phase_d  = PH_PREFIX; prefix_d = '0; left_d   = '0; acc_d    = '0;
      upage_d  = '0;        lmin_d   = '0; lmax_d   = '0; rsize_d  = '0;
      rcount_d = '0;        rid_d    = '0; chosen_d = '0; umin_d   = '0;
      umax_d   = '0;        ucount_d = '0; depth_d  = '0; devcnt_d = '1;
      pos_d    = '0;        err_d    = 1'b0; ovf_d  = 1'b0; final_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (us_we) begin
      ustore_q[ucount_q[UIDX_W-1:0]] <= data[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_PREFIX; prefix_q <= '0; left_q   <= '0; acc_q    <= '0;
      upage_q  <= '0;        lmin_q   <= '0; lmax_q   <= '0; rsize_q  <= '0;
      rcount_q <= '0;        rid_q    <= '0; chosen_q <= '0; umin_q   <= '0;
      umax_q   <= '0;        ucount_q <= '0; depth_q  <= '0; devcnt_q <= '1;
      pos_q    <= '0;        err_q    <= 1'b0; ovf_q  <= 1'b0; final_q <= 1'b0;
      mask_q   <= '0;        idx_q    <= '0; btn_q    <= 1'b0; off_q  <= '0;
      prod_q   <= '0;        valid_q  <= 1'b0;
    end else begin
      phase_q  <= phase_d;  prefix_q <= prefix_d; left_q   <= left_d;   acc_q    <= acc_d;
      upage_q  <= upage_d;  lmin_q   <= lmin_d;   lmax_q   <= lmax_d;   rsize_q  <= rsize_d;
      rcount_q <= rcount_d; rid_q    <= rid_d;    chosen_q <= chosen_d; umin_q   <= umin_d;
      umax_q   <= umax_d;   ucount_q <= ucount_d; depth_q  <= depth_d;  devcnt_q <= devcnt_d;
      pos_q    <= pos_d;    err_q    <= err_d;    ovf_q    <= ovf_d;    final_q  <= final_d;
      mask_q   <= mask_d;   idx_q    <= idx_d;    btn_q    <= btn_d;    off_q    <= off_d;
      prod_q   <= prod_d;   valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o       = res_q;
  assign res_valid_o = valid_q;

endmodule

>>> design/hid_gamepad_descriptor_parser.sv
// channel | dir | handshake     | carries
// desc_i  | in  | valid / ready | descriptor_byte, final_byte
// cap_o   | out | valid / ready | one capability or end summary per transaction
// cfg     | in  | cfg_we_i      | target_device_index, no read-back
//
// a byte inside an item is loaded; a byte that closes an item is loaded and executed
// an input item then runs the emit sequencer over each usage slot or button if it
// belongs to the chosen device, one result per cycle into the single output register
// while it is free; the final byte adds the summary, then all parse state restarts
// a stalled output holds the emit sequencer; no new byte is taken until it ends
// reset is asynchronous and active low; the usage store has no reset
module hid_gamepad_descriptor_parser #(
  parameter int unsigned USAGE_DEPTH    = hgdp_pkg::USAGE_DEPTH_DEF,
  parameter int unsigned MAX_BUTTON_RUN = hgdp_pkg::MAX_BUTTON_RUN_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  hgdp_in_if.sink    desc_i,
  hgdp_out_if.source cap_o
);
  import hgdp_pkg::*;

  cmd_t    cmd;
  status_t status;
  res_t    res;
  logic    res_valid;
  logic [7:0] target_q;

  // target device register, to be written only while idle; the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (cfg_we_i) begin
      target_q <= cfg_wdata_i;
    end
  end

  // sequencer: byte intake, item execute, emit run, position update, summary
  hgdp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (desc_i.valid),
    .in_final_i (desc_i.final_byte),
    .in_ready_o (desc_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // item decoder, parser state, usage store and output register
  hgdp_dp #(
    .USAGE_DEPTH    (USAGE_DEPTH),
    .MAX_BUTTON_RUN (MAX_BUTTON_RUN)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .byte_i      (desc_i.descriptor_byte),
    .final_i     (desc_i.final_byte),
    .target_i    (target_q),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_ready_i (cap_o.ready)
  );

  assign cap_o.valid         = res_valid;
  assign cap_o.cap_kind      = res.cap_kind;
  assign cap_o.bit_offset    = res.bit_offset;
  assign cap_o.bit_size      = res.bit_size;
  assign cap_o.logical_min   = res.logical_min;
  assign cap_o.logical_max   = res.logical_max;
  assign cap_o.usage_code    = res.usage_code;
  assign cap_o.report_length = res.report_length;
  assign cap_o.report_tag    = res.report_tag;
  assign cap_o.device_found  = res.device_found;
  assign cap_o.parse_error   = res.parse_error;
  assign cap_o.overflow_flag = res.overflow_flag;
  assign cap_o.run_last      = res.run_last;

  // a summary always closes its run
  a_summary_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cap_o.valid && (cap_o.cap_kind == CAP_SUMMARY)) |-> cap_o.run_last)
    else $error("summary without run_last");

  // capabilities are only produced for the chosen device
  a_cap_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cap_o.valid && (cap_o.cap_kind != CAP_SUMMARY)) |-> cap_o.device_found)
    else $error("capability outside chosen device");

  // at most one sequencer command per cycle
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.exec, cmd.emit, cmd.finish, cmd.summary}))
    else $error("overlapping sequencer commands");

  // summary only loads into a free output register
  a_summary_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.summary |-> status.out_free)
    else $error("summary overwrote pending result");

endmodule

>>> sim/hgdp_checker.sv
`timescale 1ns / 1ps

module hgdp_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  hgdp_in_if         desc_i,
  hgdp_out_if        cap_o,
  output int         fail_count_o,
  output int         pending_o,
  output int         caps_seen_o
);
  import hgdp_pkg::*;

  logic [7:0]  target_idx;
  phase_e      phase;
  logic [7:0]  prefix_q;
  logic [2:0]  left_q;
  logic [31:0] acc_q;
  logic [15:0] page_q;
  logic [31:0] lmin_q, lmax_q;
  logic [7:0]  size_q;
  logic [31:0] count_q;
  logic [7:0]  rep_id_q, chosen_id_q;
  logic [15:0] umin_q, umax_q;
  logic [15:0] usages [USAGE_DEPTH_DEF];
  int          n_usages;
  int          depth_q;
  int          dev_cnt;
  longint      bit_pos;
  logic        err_q, ovf_q;
  res_t        expected_caps [$];
  int          fails;
  int          seen;

  assign fail_count_o = fails;
  assign pending_o    = expected_caps.size();
  assign caps_seen_o  = seen;

  task automatic clear_state();
    phase = PH_PREFIX; prefix_q = '0; left_q = '0; acc_q = '0;
    page_q = '0; lmin_q = '0; lmax_q = '0; size_q = '0; count_q = '0;
    rep_id_q = '0; chosen_id_q = '0; umin_q = '0; umax_q = '0;
    n_usages = 0; depth_q = 0; dev_cnt = -1; bit_pos = 0;
    err_q = 1'b0; ovf_q = 1'b0;
  endtask

  task automatic push_cap(logic [1:0] kind, longint off, logic [15:0] usage);
    res_t r;
    r = '0;
    r.cap_kind      = kind;
    r.bit_offset    = (off > 65535) ? 16'hFFFF : off[15:0];
    r.bit_size      = size_q;
    r.logical_min   = lmin_q;
    r.logical_max   = lmax_q;
    r.usage_code    = usage;
    r.device_found  = 1'b1;
    r.parse_error   = err_q;
    r.overflow_flag = ovf_q;
    expected_caps.push_back(r);
  endtask

  task automatic input_item(logic [31:0] data);
    longint p;
    int     n;
    if (dev_cnt == int'(target_idx)) begin
      if (chosen_id_q != rep_id_q) begin
        chosen_id_q = rep_id_q;
        bit_pos = (bit_pos + 8 > POS_MAX) ? POS_MAX : bit_pos + 8;
      end
      if (!data[0]) begin
        if (page_q == PAGE_DESKTOP) begin
          for (int i = 0; i < n_usages; i++) begin
            if (usages[i] >= USAGE_X && usages[i] <= USAGE_RZ)
              push_cap(CAP_AXIS, bit_pos + i * size_q, usages[i]);
            else if (usages[i] == USAGE_HAT)
              push_cap(CAP_HAT, bit_pos + i * size_q, usages[i]);
          end
        end else if (page_q == PAGE_BUTTON && umax_q >= umin_q) begin
          n = int'(umax_q) - int'(umin_q) + 1;
          if (n > MAX_BUTTON_RUN_DEF) begin
            n = MAX_BUTTON_RUN_DEF;
            ovf_q = 1'b1;
          end
          for (int i = 0; i < n; i++)
            push_cap(CAP_BUTTON, bit_pos + i * size_q, umin_q + 16'(i));
        end
      end
    end
    p = bit_pos + longint'(count_q) * size_q;
    bit_pos = (p > POS_MAX) ? POS_MAX : p;
  endtask

  task automatic close_item();
    logic [1:0] typ;
    logic [3:0] tag;
    typ = prefix_q[3:2];
    tag = prefix_q[7:4];
    if (typ == TYPE_MAIN) begin
      if (tag == TAG_INPUT) input_item(acc_q);
      else if (tag == TAG_COLL && depth_q < 255) depth_q++;
      else if (tag == TAG_END_COLL && depth_q > 0) depth_q--;
      n_usages = 0; umin_q = '0; umax_q = '0;
    end else if (typ == TYPE_GLOBAL) begin
      case (tag)
        TAG_USAGE_PAGE: page_q = acc_q[15:0];
        TAG_LOG_MIN:    lmin_q = acc_q;
        TAG_LOG_MAX:    lmax_q = acc_q;
        TAG_REP_SIZE:   size_q = (acc_q > 255) ? 8'hFF : acc_q[7:0];
        TAG_REP_ID:     rep_id_q = acc_q[7:0];
        TAG_REP_COUNT:  count_q = acc_q;
        default: ;
      endcase
    end else if (typ == TYPE_LOCAL) begin
      if (tag == TAG_USAGE) begin
        if (depth_q == 0) begin
          if (dev_cnt < 255) dev_cnt++;
        end else if (n_usages < USAGE_DEPTH_DEF) begin
          usages[n_usages] = acc_q[15:0];
          n_usages++;
        end else begin
          ovf_q = 1'b1;
        end
      end else if (tag == TAG_USAGE_MIN) begin
        umin_q = acc_q[15:0];
      end else if (tag == TAG_USAGE_MAX) begin
        umax_q = acc_q[15:0];
      end
    end
  endtask

  task automatic predict_byte(logic [7:0] b, logic fin);
    int   n_prior;
    int   idx;
    res_t r;
    n_prior = expected_caps.size();
    if (phase == PH_PREFIX) begin
      prefix_q = b;
      acc_q = '0;
      if (b == LONG_PREFIX) begin
        err_q = 1'b1;
        phase = PH_SKIP;
      end else begin
        left_q = item_len(b);
        if (left_q == 0) close_item();
        else phase = PH_DATA;
      end
    end else if (phase == PH_DATA) begin
      idx = int'(item_len(prefix_q) - left_q) & 3;
      acc_q = acc_q | (32'(b) << (8 * idx));
      left_q--;
      if (left_q == 0) begin
        phase = PH_PREFIX;
        close_item();
      end
    end
    if (fin) begin
      if (phase == PH_DATA) err_q = 1'b1;
      r = '0;
      r.cap_kind      = CAP_SUMMARY;
      r.report_length = ((bit_pos + 7) / 8 > 8191) ? 13'h1FFF : 13'((bit_pos + 7) / 8);
      r.report_tag    = chosen_id_q;
      r.device_found  = (dev_cnt >= 0 && dev_cnt >= int'(target_idx));
      r.parse_error   = err_q;
      r.overflow_flag = ovf_q;
      expected_caps.push_back(r);
      clear_state();
    end
    if (expected_caps.size() > n_prior)
      expected_caps[expected_caps.size() - 1].run_last = 1'b1;
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t e;
    if (!rst_ni) begin
      target_idx = '0;
      clear_state();
      expected_caps.delete();
    end else begin
      if (cfg_we_i) target_idx = cfg_wdata_i;
      if (desc_i.valid && desc_i.ready)
        predict_byte(desc_i.descriptor_byte, desc_i.final_byte);
      if (cap_o.valid && cap_o.ready) begin
        seen++;
        if (expected_caps.size() == 0) begin
          $error("capability transaction with nothing expected");
          fails++;
        end else begin
          e = expected_caps.pop_front();
          check_field("cap_kind", 32'(e.cap_kind), 32'(cap_o.cap_kind));
          check_field("bit_offset", 32'(e.bit_offset), 32'(cap_o.bit_offset));
          check_field("bit_size", 32'(e.bit_size), 32'(cap_o.bit_size));
          check_field("logical_min", e.logical_min, cap_o.logical_min);
          check_field("logical_max", e.logical_max, cap_o.logical_max);
          check_field("usage_code", 32'(e.usage_code), 32'(cap_o.usage_code));
          check_field("report_length", 32'(e.report_length), 32'(cap_o.report_length));
          check_field("report_tag", 32'(e.report_tag), 32'(cap_o.report_tag));
          check_field("device_found", 32'(e.device_found), 32'(cap_o.device_found));
          check_field("parse_error", 32'(e.parse_error), 32'(cap_o.parse_error));
          check_field("overflow_flag", 32'(e.overflow_flag), 32'(cap_o.overflow_flag));
          check_field("run_last", 32'(e.run_last), 32'(cap_o.run_last));
        end
      end
    end
  end

  initial begin
    fails = 0;
    seen = 0;
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import hgdp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [7:0] cfg_wdata_i = '0;

  hgdp_in_if  desc_if ();
  hgdp_out_if cap_if ();

  int fail_count, pending, caps_seen;

  // pacing knobs, changed per phase
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_cycles    = 0;
  int bytes_sent     = 0;
  int descs_sent     = 0;
  int cycle_cnt      = 0;

  logic [7:0] desc_bytes [$];

  always #5 clk_i = ~clk_i;

  hid_gamepad_descriptor_parser u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .desc_i      (desc_if),
    .cap_o       (cap_if)
  );

  hgdp_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .desc_i       (desc_if),
    .cap_o        (cap_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .caps_seen_o  (caps_seen)
  );

  initial begin
    desc_if.valid = 1'b0;
    desc_if.descriptor_byte = '0;
    desc_if.final_byte = 1'b0;
    cap_if.ready = 1'b0;
  end

  // receiver: random stalls plus an optional long hold-off
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      cap_if.ready <= 1'b0;
    end else begin
      cap_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("FAIL hid_gamepad_descriptor_parser");
      $finish;
    end
  end

  // append one short item; nbytes is 0, 1, 2 or 4
  task automatic add_item(logic [1:0] typ, logic [3:0] tag, logic [31:0] data, int nbytes);
    logic [1:0] code;
    code = (nbytes == 4) ? 2'd3 : 2'(nbytes);
    desc_bytes.push_back({tag, typ, code});
    for (int i = 0; i < nbytes; i++) desc_bytes.push_back(data[8*i +: 8]);
  endtask

  function automatic int rand_width();
    int sel;
    sel = $urandom_range(3);
    return (sel == 3) ? 4 : sel;
  endfunction

  // drive one descriptor byte, holding valid until the transaction
  task automatic send_byte(logic [7:0] b, logic fin);
    if ($urandom_range(99) < send_idle_pct) begin
      desc_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    desc_if.valid <= 1'b1;
    desc_if.descriptor_byte <= b;
    desc_if.final_byte <= fin;
    @(posedge clk_i);
    while (!desc_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_descriptor();
    if (desc_bytes.size() == 0) desc_bytes.push_back(8'h00);
    foreach (desc_bytes[i]) send_byte(desc_bytes[i], i == desc_bytes.size() - 1);
    desc_bytes.delete();
    descs_sent++;
  endtask

  // idle point: everything out, then a spare wait for a byte still in flight
  task automatic drain_and_config(logic [7:0] idx);
    desc_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= idx;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // a gamepad-like descriptor with random content, sometimes damaged
  task automatic build_random_descriptor();
    int ndev, nblk, nu, w;
    logic [15:0] umin, umax;
    ndev = $urandom_range(1, 2);
    for (int d = 0; d < ndev; d++) begin
      add_item(TYPE_GLOBAL, TAG_USAGE_PAGE, 32'(PAGE_DESKTOP), 1);
      add_item(TYPE_LOCAL, TAG_USAGE, 32'h05, 1);
      add_item(TYPE_MAIN, TAG_COLL, 32'h01, 1);
      if ($urandom_range(1)) add_item(TYPE_GLOBAL, TAG_REP_ID, $urandom_range(255), 1);
      nblk = $urandom_range(1, 2);
      for (int k = 0; k < nblk; k++) begin
        if ($urandom_range(1)) begin
          add_item(TYPE_GLOBAL, TAG_USAGE_PAGE, 32'(PAGE_DESKTOP), $urandom_range(1, 2));
          nu = $urandom_range(1, 18);
          for (int u = 0; u < nu; u++) begin
            case ($urandom_range(3))
              0: add_item(TYPE_LOCAL, TAG_USAGE, 32'(USAGE_HAT), 1);
              1: add_item(TYPE_LOCAL, TAG_USAGE, $urandom, rand_width());
              default: add_item(TYPE_LOCAL, TAG_USAGE, $urandom_range(16'h30, 16'h35), 1);
            endcase
          end
          w = rand_width();
          add_item(TYPE_GLOBAL, TAG_LOG_MIN, $urandom, w);
          add_item(TYPE_GLOBAL, TAG_LOG_MAX, $urandom, rand_width());
          add_item(TYPE_GLOBAL, TAG_REP_SIZE, $urandom_range(1, 16), 1);
          add_item(TYPE_GLOBAL, TAG_REP_COUNT, $urandom_range(nu), 1);
        end else begin
          add_item(TYPE_GLOBAL, TAG_USAGE_PAGE, 32'(PAGE_BUTTON), 1);
          umin = 16'($urandom_range(1, 8));
          umax = ($urandom_range(5) == 0) ? umin - 16'd1 : umin + 16'($urandom_range(40));
          add_item(TYPE_LOCAL, TAG_USAGE_MIN, 32'(umin), 1);
          add_item(TYPE_LOCAL, TAG_USAGE_MAX, 32'(umax), $urandom_range(1, 2));
          add_item(TYPE_GLOBAL, TAG_LOG_MIN, 0, 1);
          add_item(TYPE_GLOBAL, TAG_LOG_MAX, 1, 1);
          add_item(TYPE_GLOBAL, TAG_REP_SIZE, 1, 1);
          add_item(TYPE_GLOBAL, TAG_REP_COUNT, 32'(umax) - 32'(umin) + 32'd1, 2);
        end
        // data or constant main item
        add_item(TYPE_MAIN, TAG_INPUT, ($urandom_range(7) == 0) ? 32'h01 : 32'h02, 1);
        if ($urandom_range(5) == 0) add_item(TYPE_MAIN, TAG_COLL, 32'h00, 1);
      end
      add_item(TYPE_MAIN, TAG_END_COLL, 0, 0);
    end
    // noise and broken tails
    case ($urandom_range(9))
      0: repeat ($urandom_range(1, 4)) desc_bytes.push_back(8'($urandom_range(255)));
      1: begin
        desc_bytes.push_back(LONG_PREFIX);
        repeat ($urandom_range(0, 3)) desc_bytes.push_back(8'($urandom_range(255)));
      end
      2: desc_bytes.push_back({4'($urandom_range(15)), 2'($urandom_range(3)), 2'd3});
      default: ;
    endcase
  endtask

  // hold is a receiver hold-off in cycles, started once the block is idle
  task automatic run_phase(int idle, int stall, int ndesc, logic [7:0] idx, int hold);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    drain_and_config(idx);
    hold_cycles = hold;
    for (int n = 0; n < ndesc; n++) begin
      build_random_descriptor();
      send_descriptor();
    end
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: edge values, inverted and oversize button ranges, wide globals
    add_item(TYPE_GLOBAL, TAG_USAGE_PAGE, 32'(PAGE_DESKTOP), 1);
    add_item(TYPE_LOCAL, TAG_USAGE, 32'h05, 1);
    add_item(TYPE_MAIN, TAG_COLL, 32'h01, 1);
    add_item(TYPE_GLOBAL, TAG_REP_ID, 32'hFF, 1);
    add_item(TYPE_LOCAL, TAG_USAGE, 32'(USAGE_X), 1);
    add_item(TYPE_LOCAL, TAG_USAGE, 32'(USAGE_HAT), 1);
    add_item(TYPE_GLOBAL, TAG_REP_SIZE, 32'd300, 2);
    add_item(TYPE_GLOBAL, TAG_LOG_MIN, 32'hFFFF_FF81, 4);
    add_item(TYPE_GLOBAL, TAG_LOG_MAX, 32'hFFFF_FFFF, 4);
    add_item(TYPE_GLOBAL, TAG_REP_COUNT, 32'd2, 1);
    add_item(TYPE_MAIN, TAG_INPUT, 32'h02, 1);
    add_item(TYPE_GLOBAL, TAG_USAGE_PAGE, 32'(PAGE_BUTTON), 1);
    add_item(TYPE_LOCAL, TAG_USAGE_MIN, 32'd5, 1);
    add_item(TYPE_LOCAL, TAG_USAGE_MAX, 32'd2, 1);
    add_item(TYPE_MAIN, TAG_INPUT, 32'h02, 1);
    add_item(TYPE_LOCAL, TAG_USAGE_MIN, 32'd1, 1);
    add_item(TYPE_LOCAL, TAG_USAGE_MAX, 32'hFFFF, 2);
    add_item(TYPE_MAIN, TAG_INPUT, 32'h00, 0);
    add_item(TYPE_MAIN, TAG_END_COLL, 0, 0);
    add_item(TYPE_MAIN, TAG_END_COLL, 0, 0);
    add_item(2'd3, 4'hF, 32'hAA, 1);
    add_item(TYPE_GLOBAL, TAG_REP_COUNT, 32'hFFFF_FFFF, 4);
    add_item(TYPE_MAIN, TAG_INPUT, 32'h00, 0);
    desc_bytes.push_back(LONG_PREFIX);
    desc_bytes.push_back(8'h00);
    send_descriptor();
    // truncated item on the last byte
    desc_bytes.push_back(8'h27);
    send_descriptor();

    // long receiver hold-off while the sender keeps offering bytes
    run_phase(0, 0, 1, 8'd0, 200);
    run_phase(74, 0, 1, 8'd1, 0);
    run_phase(0, 74, 1, 8'd255, 0);
    run_phase(18, 18, 1, 8'($urandom_range(2)), 0);

    desc_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    $display("sent %0d descriptor bytes in %0d descriptors, checked %0d results",
             bytes_sent, descs_sent, caps_seen);
    $display("target indexes 0, 1, 255 and a random pick under four pacing mixes, one long stall");
    if (fail_count == 0 && pending == 0) begin
      $display("PASS hid_gamepad_descriptor_parser");
    end else begin
      $display("FAIL hid_gamepad_descriptor_parser");
    end
    $finish;
  end

endmodule
